@@ design/lspc_pkg.sv @@
`timescale 1ns / 1ps

package lspc_pkg;

   localparam int ADDR_BITS      = 16;
   localparam int FRAC_BITS      = 16;
   localparam int POS_BITS       = ADDR_BITS + FRAC_BITS;
   localparam int STEP_BITS      = 24;
   localparam int LOOP_BITS      = 16;
   localparam int LOAD_ADDR_BITS = 16;
   localparam int SAMPLE_BITS    = 16;
   localparam int OUT_BITS       = 17;
   localparam int KIND_BITS      = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;
   localparam int U_BITS         = 17;
   localparam int U_FRAC_BITS    = 16;

   // signed width that holds positions, loop points and the step with headroom
   localparam int WIDE_BITS = ((POS_BITS > STEP_BITS) ? POS_BITS : STEP_BITS) + 3;
   // unsigned width that holds a 16-bit field or a memory index
   localparam int EXT_BITS  = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 1;
   // signed width of a neighbor index before clamping
   localparam int IDX_BITS  = ADDR_BITS + 2;
   localparam int MAX_INDEX = (1 << ADDR_BITS) - 1;

   localparam logic [STEP_BITS-1:0] STEP_RATE_RESET  = STEP_BITS'(131072);
   localparam logic [LOOP_BITS-1:0] LOOP_START_RESET = LOOP_BITS'(0);
   localparam logic [LOOP_BITS-1:0] LOOP_END_RESET   = LOOP_BITS'(65535);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_TICK    = 2'd1,
      KIND_TRIGGER = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STEP_RATE  = 2'd0,
      CSR_LOOP_START = 2'd1,
      CSR_LOOP_END   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POS,
      ST_ADDR,
      ST_READ,
      ST_LAST,
      ST_INTERP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] a;
      logic signed [SAMPLE_BITS-1:0] b;
      logic signed [SAMPLE_BITS-1:0] c;
      logic signed [SAMPLE_BITS-1:0] d;
   } quad_type;

   function automatic logic [ADDR_BITS-1:0] loop_index(input logic [LOOP_BITS-1:0] v);
      logic [EXT_BITS-1:0] e;
      e = EXT_BITS'(v);
      if (e > EXT_BITS'(MAX_INDEX)) e = EXT_BITS'(MAX_INDEX);
      return e[ADDR_BITS-1:0];
   endfunction

   function automatic logic [ADDR_BITS-1:0] load_index(input logic [LOAD_ADDR_BITS-1:0] v);
      logic [EXT_BITS-1:0] e;
      e = EXT_BITS'(v);
      return e[ADDR_BITS-1:0];
   endfunction

   function automatic logic [ADDR_BITS-1:0] clamp_hi(input logic signed [IDX_BITS-1:0] v);
      logic [ADDR_BITS-1:0] r;
      if (v > IDX_BITS'(MAX_INDEX)) r = ADDR_BITS'(MAX_INDEX);
      else r = v[ADDR_BITS-1:0];
      return r;
   endfunction

   function automatic logic [ADDR_BITS-1:0] clamp_lo(input logic signed [IDX_BITS-1:0] v);
      logic [ADDR_BITS-1:0] r;
      if (v < 0) r = '0;
      else r = v[ADDR_BITS-1:0];
      return r;
   endfunction

   // fraction brought to 16 bits: truncated or zero-filled
   function automatic logic [U_FRAC_BITS-1:0] frac16(input logic [FRAC_BITS-1:0] f);
      logic [FRAC_BITS+U_FRAC_BITS-1:0] t;
      t = {f, {U_FRAC_BITS{1'b0}}};
      return t[FRAC_BITS+U_FRAC_BITS-1:FRAC_BITS];
   endfunction

endpackage

@@ design/lspc_req_if.sv @@
`timescale 1ns / 1ps

interface lspc_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [lspc_pkg::KIND_BITS-1:0]           kind;
   logic [lspc_pkg::LOAD_ADDR_BITS-1:0]      sample_address;
   logic signed [lspc_pkg::SAMPLE_BITS-1:0]  sample_word;

   modport source (output valid, output kind, output sample_address, output sample_word,
                   input ready);
   modport sink   (input valid, input kind, input sample_address, input sample_word,
                   output ready);
endinterface

@@ design/lspc_rsp_if.sv @@
`timescale 1ns / 1ps

interface lspc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lspc_pkg::OUT_BITS-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

@@ design/lspc_interp.sv @@
`timescale 1ns / 1ps

module lspc_interp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  lspc_pkg::quad_type                   quad,
   input  logic signed [lspc_pkg::U_BITS-1:0]   u,
   output logic                                 done,
   output logic signed [lspc_pkg::OUT_BITS-1:0] y
);

   localparam int CW  = 21;
   localparam int A1W = 17;
   localparam int A2W = 20;
   localparam int A3W = 19;
   localparam int HW  = 42;
   localparam int UW  = lspc_pkg::U_BITS;
   localparam int SH  = lspc_pkg::U_FRAC_BITS;

   localparam logic signed [HW-1:0] ROUND_HALF = HW'(1) <<< SH;
   localparam logic signed [HW-1:0] SAT_HI = HW'((1 << (lspc_pkg::OUT_BITS - 1)) - 1);
   localparam logic signed [HW-1:0] SAT_LO = HW'(-(1 << (lspc_pkg::OUT_BITS - 1)));

   logic signed [CW-1:0]           sa, sb, sc, sd, bc;
   logic signed [CW-1:0]           a1, a2, a3;
   logic signed [A1W-1:0]          a1_ff;
   logic signed [A2W-1:0]          a2_ff;
   logic signed [A3W-1:0]          a3_ff;
   logic signed [lspc_pkg::SAMPLE_BITS-1:0] b_ff;
   logic signed [UW-1:0]           u_ff;
   logic signed [A3W+UW-1:0]       m1;
   logic signed [HW+UW-1:0]        mh;
   logic signed [HW-1:0]           h1, h2, h3, r;
   logic signed [HW-1:0]           h_ff;
   logic signed [lspc_pkg::OUT_BITS-1:0] y_in, y_ff;
   logic [3:0]                     v_ff;

   // doubled hermite coefficients
   always_comb begin
      sa = CW'(quad.a);
      sb = CW'(quad.b);
      sc = CW'(quad.c);
      sd = CW'(quad.d);
      bc = sb - sc;
      a1 = sc - sa;
      a2 = (sa <<< 1) - ((sb <<< 2) + sb) + (sc <<< 2) - sd;
      a3 = (sd - sa) + ((bc <<< 1) + bc);
   end

   // horner steps at scale 2^16
   always_comb begin
      m1 = a3_ff * u_ff;
      mh = h_ff * u_ff;
      h1 = HW'(m1) + (HW'(a2_ff) <<< SH);
      h2 = HW'(mh >>> SH) + (HW'(a1_ff) <<< SH);
      h3 = HW'(mh >>> SH) + (HW'(b_ff) <<< (SH + 1));
      r  = (h3 + ROUND_HALF) >>> (SH + 1);
      if (r > SAT_HI) y_in = SAT_HI[lspc_pkg::OUT_BITS-1:0];
      else if (r < SAT_LO) y_in = SAT_LO[lspc_pkg::OUT_BITS-1:0];
      else y_in = r[lspc_pkg::OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], go};
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         a1_ff <= A1W'(a1);
         a2_ff <= A2W'(a2);
         a3_ff <= A3W'(a3);
         b_ff  <= quad.b;
         u_ff  <= u;
      end
      if (v_ff[0]) h_ff <= h1;
      if (v_ff[1]) h_ff <= h2;
      if (v_ff[2]) y_ff <= y_in;
   end

   assign done = v_ff[3];
   assign y    = y_ff;

endmodule

@@ design/looping_sample_player_cubic.sv @@
`timescale 1ns / 1ps

// Looping sample player with cubic Hermite interpolation.
// req_bus carries items: load writes sample_word at sample_address, trigger puts the
// play position at the loop start, tick advances the position by step_rate, wraps it
// inside the loop and returns one interpolated sample on rsp_bus. Other kinds do nothing.
// csr_write with csr_index 0/1/2 sets step_rate, loop_start, loop_end; write them only
// while the block is idle.
// Load and trigger complete in the cycle they are taken. A tick runs through a
// sequencer: position update, neighbor address, four reads of the single-port sample
// memory, then a four-stage Horner unit. The result becomes valid in the cycle
// req_bus is ready again, so a new tick is taken only once the last one is done.
// The result sits in an output register, so the next item is taken while it waits.
// If rsp_bus is stalled when a new result is ready, the sequencer holds it until the
// output register is free.
// Reset clears the play position and sets the registers to step 2.0, loop 0 to 65535.
// The sample memory is not cleared: read only entries that were loaded.

module looping_sample_player_cubic (
   input  logic                                  clock,
   input  logic                                  reset,
   lspc_req_if.sink                              req_bus,
   lspc_rsp_if.source                            rsp_bus,
   input  logic                                  csr_write,
   input  logic [lspc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lspc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int AB = lspc_pkg::ADDR_BITS;
   localparam int FB = lspc_pkg::FRAC_BITS;
   localparam int PB = lspc_pkg::POS_BITS;
   localparam int WB = lspc_pkg::WIDE_BITS;
   localparam int IB = lspc_pkg::IDX_BITS;
   localparam int UB = lspc_pkg::U_BITS;

   localparam logic signed [WB-1:0] ONE_POS = WB'(1) <<< FB;
   localparam logic signed [WB-1:0] POS_MAX = (WB'(1) <<< PB) - WB'(1);

   lspc_pkg::state_type state_ff, state_in;

   logic signed [lspc_pkg::STEP_BITS-1:0] step_ff;
   logic [lspc_pkg::LOOP_BITS-1:0]        lstart_ff, lend_ff;
   logic [PB-1:0]                         play_ff, play_in;
   logic [1:0]                            cnt_ff;
   logic [AB-1:0]                         addr_ff [4];
   logic [AB-1:0]                         addr_in [4];
   logic signed [UB-1:0]                  u_ff, u_in;
   logic signed [lspc_pkg::SAMPLE_BITS-1:0] qa_ff, qb_ff, qc_ff;
   lspc_pkg::quad_type                    quad_go;
   logic                                  rsp_valid_ff;
   logic signed [lspc_pkg::OUT_BITS-1:0]  rsp_data_ff;

   logic signed [lspc_pkg::SAMPLE_BITS-1:0] sample_mem [1 << AB];
   logic signed [lspc_pkg::SAMPLE_BITS-1:0] rdata_ff;

   logic            req_fire, mem_we, mem_re, interp_go, out_load, fwd;
   logic [AB-1:0]   mem_addr, idx;
   logic [PB-1:0]   s_full, e_full, new_pos;
   logic signed [WB-1:0] s_w, e_w, play_w, step_w, base_w, sum_w;
   logic signed [IB-1:0] idx_e;
   logic [lspc_pkg::U_FRAC_BITS-1:0] f16;
   logic            interp_done;
   logic signed [lspc_pkg::OUT_BITS-1:0] interp_y;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign fwd      = !step_ff[lspc_pkg::STEP_BITS-1] && (step_ff != '0);

   // loop points in position units
   always_comb begin
      s_full = {lspc_pkg::loop_index(lstart_ff), {FB{1'b0}}};
      e_full = {lspc_pkg::loop_index(lend_ff), {FB{1'b0}}};
      s_w    = $signed(WB'(s_full));
      e_w    = $signed(WB'(e_full));
      play_w = $signed(WB'(play_ff));
      step_w = WB'(step_ff);
   end

   // wrap, step and saturate the position
   always_comb begin
      if (fwd) begin
         base_w = (play_w < s_w || play_w >= e_w) ? s_w : play_w;
         sum_w  = base_w + step_w;
         if (sum_w > POS_MAX) sum_w = POS_MAX;
      end else begin
         base_w = (play_w <= s_w) ? e_w : play_w;
         sum_w  = base_w + step_w;
         if (sum_w < 0) sum_w = '0;
      end
      new_pos = sum_w[PB-1:0];
   end

   // neighbor addresses, sample 0 where a neighbor falls outside the loop
   always_comb begin
      idx   = play_ff[PB-1:FB];
      idx_e = $signed(IB'(idx));
      f16   = lspc_pkg::frac16(play_ff[FB-1:0]);
      addr_in[1] = idx;
      if (fwd) begin
         addr_in[0] = lspc_pkg::clamp_lo(idx_e - IB'(1));
         addr_in[2] = (play_w < e_w - (ONE_POS <<< 1)) ?
                      lspc_pkg::clamp_hi(idx_e + IB'(1)) : '0;
         addr_in[3] = (play_w < e_w - ((ONE_POS <<< 1) + ONE_POS)) ?
                      lspc_pkg::clamp_hi(idx_e + IB'(2)) : '0;
         u_in = $signed({1'b0, f16});
      end else begin
         addr_in[0] = (play_w > s_w && play_w < e_w - ONE_POS) ?
                      lspc_pkg::clamp_hi(idx_e + IB'(1)) : '0;
         addr_in[2] = (play_w > s_w) ? lspc_pkg::clamp_lo(idx_e - IB'(1)) : '0;
         addr_in[3] = (play_w > s_w + ONE_POS) ? lspc_pkg::clamp_lo(idx_e - IB'(2)) : '0;
         u_in = -$signed({1'b0, f16});
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lspc_pkg::ST_IDLE: begin
            if (req_fire && req_bus.kind == lspc_pkg::KIND_TICK) state_in = lspc_pkg::ST_POS;
         end
         lspc_pkg::ST_POS:  state_in = lspc_pkg::ST_ADDR;
         lspc_pkg::ST_ADDR: state_in = lspc_pkg::ST_READ;
         lspc_pkg::ST_READ: begin
            if (cnt_ff == 2'd3) state_in = lspc_pkg::ST_LAST;
         end
         lspc_pkg::ST_LAST: state_in = lspc_pkg::ST_INTERP;
         lspc_pkg::ST_INTERP: begin
            if (interp_done) state_in = lspc_pkg::ST_OUT;
         end
         lspc_pkg::ST_OUT: begin
            if (out_load) state_in = lspc_pkg::ST_IDLE;
         end
         default: state_in = lspc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_bus.ready = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      interp_go     = 1'b0;
      out_load      = 1'b0;
      mem_addr      = lspc_pkg::load_index(req_bus.sample_address);
      case (state_ff)
         lspc_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            mem_we = req_bus.valid && req_bus.kind == lspc_pkg::KIND_LOAD;
         end
         lspc_pkg::ST_READ: begin
            mem_re   = 1'b1;
            mem_addr = addr_ff[cnt_ff];
         end
         lspc_pkg::ST_LAST: interp_go = 1'b1;
         lspc_pkg::ST_OUT:  out_load = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   always_comb begin
      play_in = play_ff;
      if (state_ff == lspc_pkg::ST_IDLE && req_fire &&
          req_bus.kind == lspc_pkg::KIND_TRIGGER) begin
         play_in = s_full;
      end else if (state_ff == lspc_pkg::ST_POS) begin
         play_in = new_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lspc_pkg::ST_IDLE;
         play_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= lspc_pkg::STEP_RATE_RESET;
         lstart_ff    <= lspc_pkg::LOOP_START_RESET;
         lend_ff      <= lspc_pkg::LOOP_END_RESET;
      end else begin
         state_ff <= state_in;
         play_ff  <= play_in;
         if (state_ff == lspc_pkg::ST_ADDR) cnt_ff <= '0;
         else if (state_ff == lspc_pkg::ST_READ) cnt_ff <= cnt_ff + 2'd1;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               lspc_pkg::CSR_STEP_RATE:  step_ff   <= csr_wdata[lspc_pkg::STEP_BITS-1:0];
               lspc_pkg::CSR_LOOP_START: lstart_ff <= csr_wdata[lspc_pkg::LOOP_BITS-1:0];
               lspc_pkg::CSR_LOOP_END:   lend_ff   <= csr_wdata[lspc_pkg::LOOP_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // sample memory, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) sample_mem[mem_addr] <= req_bus.sample_word;
      if (mem_re) rdata_ff <= sample_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == lspc_pkg::ST_ADDR) begin
         addr_ff <= addr_in;
         u_ff    <= u_in;
      end
      if (state_ff == lspc_pkg::ST_READ) begin
         case (cnt_ff)
            2'd1: qa_ff <= rdata_ff;
            2'd2: qb_ff <= rdata_ff;
            2'd3: qc_ff <= rdata_ff;
            default: ;
         endcase
      end
      if (out_load) rsp_data_ff <= interp_y;
   end

   always_comb begin
      quad_go.a = qa_ff;
      quad_go.b = qb_ff;
      quad_go.c = qc_ff;
      quad_go.d = rdata_ff;
   end

   lspc_interp u_interp (
      .clock (clock),
      .reset (reset),
      .go    (interp_go),
      .quad  (quad_go),
      .u     (u_ff),
      .done  (interp_done),
      .y     (interp_y)
   );

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_data_ff;

endmodule

@@ design/lspc_checker.sv @@
`timescale 1ns / 1ps

module lspc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [lspc_pkg::KIND_BITS-1:0]       req_kind,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [lspc_pkg::OUT_BITS-1:0]        rsp_sample_out
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("result dropped or changed while stalled");

   // a tick keeps the block busy the next cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == lspc_pkg::KIND_TICK |=> !req_ready)
      else $error("ready right after a tick transfer");

   // load, trigger and unknown kinds give no result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind != lspc_pkg::KIND_TICK && !rsp_valid |=> !rsp_valid)
      else $error("result after an item that gives none");

   // a fresh result comes with the input side open again
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result shown while still busy");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind looping_sample_player_cubic lspc_checker u_lspc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_kind       (req_bus.kind),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_sample_out (rsp_bus.sample_out)
);

@@ test/lspc_playback_checker.sv @@
`timescale 1ns / 1ps

module lspc_playback_checker
   import lspc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   lspc_req_if                       req_bus,
   lspc_rsp_if                       rsp_bus,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fault_count
);

   localparam longint ONE_SAMPLE = longint'(1) << FRAC_BITS;
   localparam longint POS_LIMIT  = (longint'(1) << POS_BITS) - 1;

   logic signed [SAMPLE_BITS-1:0] sample_mem [0:MAX_INDEX];
   logic signed [STEP_BITS-1:0]   step_rate;
   logic [LOOP_BITS-1:0]          loop_start;
   logic [LOOP_BITS-1:0]          loop_end;
   longint                        play_pos;
   logic signed [OUT_BITS-1:0]    expected_levels [$];
   logic signed [OUT_BITS-1:0]    want;
   int                            mismatches;

   initial begin
      for (int i = 0; i <= MAX_INDEX; i++) sample_mem[i] = '0;
      mismatches  = 0;
      fault_count = 0;
   end

   function automatic longint sample_at(longint i);
      if (i < 0) i = 0;
      if (i > MAX_INDEX) i = MAX_INDEX;
      return longint'(sample_mem[i]);
   endfunction

   function automatic longint loop_point(logic [LOOP_BITS-1:0] v);
      longint p;
      p = longint'(v);
      if (p > MAX_INDEX) p = MAX_INDEX;
      return p << FRAC_BITS;
   endfunction

   // fraction of the position at 16 bits
   function automatic longint pos_fraction(longint p);
      longint f;
      f = p & (ONE_SAMPLE - 1);
      if (FRAC_BITS >= 16) return f >> (FRAC_BITS - 16);
      return f << (16 - FRAC_BITS);
   endfunction

   // horner steps on doubled coefficients, result rounded half up and saturated
   function automatic logic signed [OUT_BITS-1:0] cubic_level(longint a, longint b, longint c,
                                                               longint d, longint u);
      longint k1, k2, k3, h;
      k1 = c - a;
      k2 = 2 * a - 5 * b + 4 * c - d;
      k3 = (d - a) + 3 * (b - c);
      h = k3 * u + (k2 <<< 16);
      h = ((h * u) >>> 16) + (k1 <<< 16);
      h = ((h * u) >>> 16) + (b <<< 17);
      h = (h + 65536) >>> 17;
      if (h > 65535) h = 65535;
      if (h < -65536) h = -65536;
      return OUT_BITS'(h);
   endfunction

   function automatic logic signed [OUT_BITS-1:0] advance_and_interpolate();
      longint s_pos, e_pos, p, idx, a, b, c, d, rate;
      logic signed [OUT_BITS-1:0] level;
      s_pos = loop_point(loop_start);
      e_pos = loop_point(loop_end);
      rate  = longint'(step_rate);
      p     = play_pos;
      if (rate > 0) begin
         if (p < s_pos) p = s_pos;
         if (p >= e_pos) p = s_pos;
         p = p + rate;
         if (p > POS_LIMIT) p = POS_LIMIT;
         idx = p >>> FRAC_BITS;
         a = (idx > 0) ? sample_at(idx - 1) : sample_at(0);
         b = sample_at(idx);
         c = (p < e_pos - 2 * ONE_SAMPLE) ? sample_at(idx + 1) : sample_at(0);
         d = (p < e_pos - 3 * ONE_SAMPLE) ? sample_at(idx + 2) : sample_at(0);
         level = cubic_level(a, b, c, d, pos_fraction(p));
      end else begin
         if (p <= s_pos) p = e_pos;
         p = p + rate;
         if (p < 0) p = 0;
         idx = p >>> FRAC_BITS;
         a = (p > s_pos && p < e_pos - ONE_SAMPLE) ? sample_at(idx + 1) : sample_at(0);
         b = sample_at(idx);
         c = (p > s_pos) ? sample_at(idx - 1) : sample_at(0);
         d = (p > s_pos + ONE_SAMPLE) ? sample_at(idx - 2) : sample_at(0);
         level = cubic_level(a, b, c, d, -pos_fraction(p));
      end
      play_pos = p;
      return level;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         step_rate  = STEP_RATE_RESET;
         loop_start = LOOP_START_RESET;
         loop_end   = LOOP_END_RESET;
         play_pos   = 0;
         expected_levels.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_levels.size() == 0) begin
               mismatches++;
               $display("%0t: sample_out expected none actual %0d", $time, rsp_bus.sample_out);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_bus.sample_out !== want) begin
                  mismatches++;
                  $display("%0t: sample_out expected %0d actual %0d",
                           $time, want, rsp_bus.sample_out);
               end
            end
         end
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_STEP_RATE:  step_rate  = csr_wdata[STEP_BITS-1:0];
               CSR_LOOP_START: loop_start = csr_wdata[LOOP_BITS-1:0];
               CSR_LOOP_END:   loop_end   = csr_wdata[LOOP_BITS-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            case (kind_type'(req_bus.kind))
               KIND_LOAD:    sample_mem[req_bus.sample_address[ADDR_BITS-1:0]] = req_bus.sample_word;
               KIND_TICK:    expected_levels.push_back(advance_and_interpolate());
               KIND_TRIGGER: play_pos = loop_point(loop_start);
               default: ;
            endcase
         end
      end
      fault_count = mismatches + expected_levels.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   csr_write;
   lspc_pkg::csr_index_type                csr_index;
   logic [lspc_pkg::CSR_DATA_BITS-1:0]     csr_wdata;
   int                                     fault_count;
   int                                     ticks_sent = 0;
   int                                     levels_seen = 0;
   bit                                     idling;
   bit                                     hold_pending;
   bit                                     hold_done;
   bit                                     loaded [0:lspc_pkg::MAX_INDEX];

   lspc_req_if req_bus ();
   lspc_rsp_if rsp_bus ();

   looping_sample_player_cubic u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lspc_playback_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fault_count (fault_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) levels_seen <= levels_seen + 1;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      hold_done     = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_pending && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            hold_done = 1'b1;
            repeat (300) @(posedge clock);
         end else if (idling && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [lspc_pkg::SAMPLE_BITS-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         default: return lspc_pkg::SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic send_item(lspc_pkg::kind_type k,
                            logic [lspc_pkg::LOAD_ADDR_BITS-1:0] addr,
                            logic [lspc_pkg::SAMPLE_BITS-1:0] word);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.kind           <= k;
      req_bus.sample_address <= addr;
      req_bus.sample_word    <= word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (k == lspc_pkg::KIND_TICK) ticks_sent++;
      if (k == lspc_pkg::KIND_LOAD) loaded[addr] = 1'b1;
   endtask

   task automatic drain_and_pause();
      req_bus.valid <= 1'b0;
      while (levels_seen != ticks_sent) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_loop(longint rate, int first, int last);
      csr_write <= 1'b1;
      csr_index <= lspc_pkg::CSR_STEP_RATE;
      csr_wdata <= lspc_pkg::CSR_DATA_BITS'(rate);
      @(posedge clock);
      csr_index <= lspc_pkg::CSR_LOOP_START;
      csr_wdata <= lspc_pkg::CSR_DATA_BITS'(first);
      @(posedge clock);
      csr_index <= lspc_pkg::CSR_LOOP_END;
      csr_wdata <= lspc_pkg::CSR_DATA_BITS'(last);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // loads every sample the loop can reach within count ticks, then plays it
   task automatic run_phase(longint rate, int first, int last, int count, bit with_hold);
      longint lo, hi, up, down, span;
      int     roll;
      drain_and_pause();
      set_loop(rate, first, last);
      up   = (rate + 65535) / 65536;
      down = (65535 - rate) / 65536;
      if (rate > 0) begin
         lo = first - 1;
         if (first < last) begin
            span = first + count * up;
            hi = ((span < last) ? span : last) + up + 3;
         end else begin
            hi = first + up + 3;
         end
      end else begin
         hi = last + 2;
         if (first < last) begin
            span = last - count * down;
            lo = ((span > first) ? span : first) - down - 3;
         end else begin
            lo = last - down - 3;
         end
      end
      if (lo < 0) lo = 0;
      if (hi > lspc_pkg::MAX_INDEX) hi = lspc_pkg::MAX_INDEX;
      if (!loaded[0]) send_item(lspc_pkg::KIND_LOAD, '0, pick_word());
      for (longint i = lo; i <= hi; i++) begin
         if (!loaded[i])
            send_item(lspc_pkg::KIND_LOAD, lspc_pkg::LOAD_ADDR_BITS'(i), pick_word());
      end
      send_item(lspc_pkg::KIND_TRIGGER, lspc_pkg::LOAD_ADDR_BITS'($urandom),
                lspc_pkg::SAMPLE_BITS'($urandom));
      if (with_hold) hold_pending <= 1'b1;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 70)
            send_item(lspc_pkg::KIND_TICK, lspc_pkg::LOAD_ADDR_BITS'($urandom),
                      lspc_pkg::SAMPLE_BITS'($urandom));
         else if (roll < 78)
            send_item(lspc_pkg::KIND_LOAD,
                      lspc_pkg::LOAD_ADDR_BITS'($urandom_range(int'(lo), int'(hi))),
                      pick_word());
         else if (roll < 84)
            send_item(lspc_pkg::KIND_LOAD, lspc_pkg::LOAD_ADDR_BITS'($urandom), pick_word());
         else if (roll < 93)
            send_item(lspc_pkg::KIND_TRIGGER, lspc_pkg::LOAD_ADDR_BITS'($urandom),
                      lspc_pkg::SAMPLE_BITS'($urandom));
         else
            send_item(lspc_pkg::KIND_NONE, lspc_pkg::LOAD_ADDR_BITS'($urandom),
                      lspc_pkg::SAMPLE_BITS'($urandom));
      end
   endtask

   task automatic random_phase(int count);
      int     base, first, last, swap;
      longint rate;
      base  = ($urandom_range(0, 1) == 1) ? 65470 : 0;
      first = base + $urandom_range(0, 40);
      last  = first + $urandom_range(0, 40);
      if (last > lspc_pkg::MAX_INDEX) last = lspc_pkg::MAX_INDEX;
      if ($urandom_range(0, 4) == 0) begin
         swap  = first;
         first = last;
         last  = swap;
      end
      case ($urandom_range(0, 5))
         0:       rate = 0;
         1, 2:    rate = -longint'($urandom_range(1, 3 * 65536));
         default: rate = longint'($urandom_range(1, 3 * 65536));
      endcase
      run_phase(rate, first, last, count, 1'b0);
   endtask

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.kind           = lspc_pkg::KIND_NONE;
      req_bus.sample_address = '0;
      req_bus.sample_word    = '0;
      csr_write              = 1'b0;
      csr_index              = lspc_pkg::CSR_STEP_RATE;
      csr_wdata              = '0;
      idling                 = 1'b1;
      hold_pending           = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: step 2.0 over the whole memory
      for (int i = 0; i < 4; i++)
         send_item(lspc_pkg::KIND_LOAD, 16'(i), (i % 2 == 1) ? 16'h8000 : 16'h7fff);
      for (int i = 4; i < 10; i++) send_item(lspc_pkg::KIND_LOAD, 16'(i), pick_word());
      send_item(lspc_pkg::KIND_LOAD, 16'hffff, 16'h8000);
      send_item(lspc_pkg::KIND_NONE, 16'hffff, 16'hffff);
      repeat (3) send_item(lspc_pkg::KIND_TICK, 16'hffff, 16'h0000);
      send_item(lspc_pkg::KIND_TRIGGER, 16'h0000, 16'hffff);
      send_item(lspc_pkg::KIND_TICK, 16'h0000, 16'h0000);
      send_item(lspc_pkg::KIND_NONE, 16'h0000, 16'h0000);

      run_phase(65536 + longint'($urandom_range(0, 65535)), 3, 40, 30, 1'b0);
      run_phase(-longint'($urandom_range(1, 131071)), 5, 48, 30, 1'b0);
      run_phase(8388607, 0, 30, 25, 1'b0);
      run_phase(-8388608, 40, 150, 25, 1'b0);
      // position saturates at the top, then clamps at zero
      run_phase(longint'($urandom_range(2 * 65536, 6 * 65536)), lspc_pkg::MAX_INDEX, 0,
                15, 1'b0);
      run_phase(-longint'($urandom_range(1, 4 * 65536)), lspc_pkg::MAX_INDEX, 0, 15, 1'b0);
      run_phase(0, 20, 60, 15, 1'b0);
      run_phase(longint'($urandom_range(1, 2 * 65536)), 120, 120, 15, 1'b0);
      run_phase(longint'($urandom_range(32768, 98304)), 10, 150, 60, 1'b1);
      repeat (5) random_phase(35);
      idling <= 1'b0;
      random_phase(50);
      drain_and_pause();

      if (fault_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
